[src/cbps_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// cbps_pkg
// Shared types and constants of the bichromatic close-pair sweep block.
// ============================================================================
package cbps_pkg;

   localparam int COORD_W   = 14;
   localparam int RADIUS_W  = 12;
   localparam int PCOUNT_W  = 11;
   localparam int TOTAL_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int LIMIT_W   = 2 * RADIUS_W + 4;
   localparam logic [PCOUNT_W-1:0] COUNT_SAT = '1;

   localparam logic OP_ENTER = 1'b0;
   localparam logic OP_LEAVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic             color;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic commit;
      logic ins_write;
      logic move_read;
      logic move_write;
      logic rsp_load;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pipe_empty;
      logic match;
      logic full;
      logic leave;
      logic last;
   } stat_type;

endpackage

[src/cbps_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// cbps_ctrl
// Sequencer of the sweep block: event intake, table scan, update, response.
// ============================================================================
module cbps_ctrl
   import cbps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = !st.scan_done;
            if (st.scan_done && st.pipe_empty) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.commit    = 1'b1;
            cmd.ins_write = !st.leave && !st.match && !st.full;
            state_in      = (st.leave && st.match) ? S_MOVE_RD : S_RESP;
         end
         S_MOVE_RD: begin
            cmd.move_read = 1'b1;
            state_in      = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.move_write = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               cmd.clear    = st.last;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/cbps_dp.sv]
`timescale 1ns / 1ps
// ============================================================================
// cbps_dp
// Datapath: point table, scan pipeline, distance test, totals, response regs.
// ============================================================================
module cbps_dp
   import cbps_pkg::*;
#(
   parameter int CAPACITY  = 1024,
   parameter int COORD_MAX = 10000
)(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            st,
   input  logic                req_op,
   input  logic [COORD_W-1:0]  req_pos_x,
   input  logic [COORD_W-1:0]  req_pos_y,
   input  logic                req_color,
   input  logic                req_last,
   input  logic                csr_wr_en,
   input  logic [RADIUS_W-1:0] csr_wr_data,
   output logic [PCOUNT_W-1:0] rsp_pair_count,
   output logic [TOTAL_W-1:0]  rsp_running_total,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_final_res
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CX_W  = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;
   localparam logic [16:0] CMAX = 17'(COORD_MAX);

   // event registers
   logic               op_ff, col_ff, fin_ff;
   logic [COORD_W-1:0] px_ff, py_ff, px_in, py_in;

   // table and scan control
   entry_type          mem [CAPACITY];
   entry_type          rd_data_ff, wr_data;
   logic [CNT_W-1:0]   fill_ff, fill_m1, ptr_ff;
   logic [IDX_W-1:0]   rd_idx, wr_idx, match_idx_ff;
   logic               rd_en, wr_en, match_ff;

   // pipeline
   logic               s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [SQ_W:0]      dist_sq;
   logic [CNT_W-1:0]   count_ff;

   // configuration and totals
   logic [RADIUS_W-1:0]   radius_ff;
   logic [2*RADIUS_W-1:0] r_sq;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic [TOTAL_W:0]      total_sum;
   status_type            status_ff, status_in;
   logic [CX_W-1:0]       count_ext;
   logic [PCOUNT_W-1:0]   count_sat;

   assign px_in = ({3'b000, req_pos_x} > CMAX) ? CMAX[COORD_W-1:0] : req_pos_x;
   assign py_in = ({3'b000, req_pos_y} > CMAX) ? CMAX[COORD_W-1:0] : req_pos_y;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         col_ff <= req_color;
         fin_ff <= req_last;
         px_ff  <= px_in;
         py_ff  <= py_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_W'(1);
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   assign r_sq = radius_ff * radius_ff;

   always_ff @(posedge clock) begin
      limit_ff <= {r_sq, 4'b0000};
   end

   // table memory: one read port, one write port
   assign fill_m1 = fill_ff - 1'b1;
   assign rd_en   = cmd.scan_step || cmd.move_read;
   assign rd_idx  = cmd.move_read ? fill_m1[IDX_W-1:0] : ptr_ff[IDX_W-1:0];
   assign wr_en   = cmd.ins_write || cmd.move_write;
   assign wr_idx  = cmd.ins_write ? fill_ff[IDX_W-1:0] : match_idx_ff;
   assign wr_data = cmd.ins_write ? entry_type'({col_ff, py_ff, px_ff}) : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   // fill count keeps the table packed; a leave moves the top entry into the hole
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         fill_ff <= '0;
      end else if (cmd.ins_write) begin
         fill_ff <= fill_ff + 1'b1;
      end else if (cmd.move_write) begin
         fill_ff <= fill_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ptr_ff <= '0;
      end else if (cmd.scan_step) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
   end

   // stage 2: color split, duplicate match, coordinate differences
   assign dx_in = (rd_data_ff.x > px_ff) ? rd_data_ff.x - px_ff : px_ff - rd_data_ff.x;
   assign dy_in = (rd_data_ff.y > py_ff) ? rd_data_ff.y - py_ff : py_ff - rd_data_ff.y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.scan_step;
         s2_vld_ff <= s1_vld_ff && (rd_data_ff.color != col_ff) && (op_ff == OP_ENTER);
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= rd_idx;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sqx_ff    <= dx_ff * dx_ff;
      sqy_ff    <= dy_ff * dy_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         match_ff <= 1'b0;
      end else if (s1_vld_ff && (rd_data_ff.color == col_ff) && !match_ff &&
                   (rd_data_ff.x == px_ff) && (rd_data_ff.y == py_ff)) begin
         match_ff     <= 1'b1;
         match_idx_ff <= s1_idx_ff;
      end
   end

   // stage 4: squared distance against 16 r^2
   assign dist_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff <= '0;
      end else if (s3_vld_ff && (dist_sq <= (SQ_W+1)'(limit_ff))) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // totals and status
   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(count_ff);

   always_comb begin
      if (op_ff == OP_LEAVE) begin
         status_in = match_ff ? ST_OK : ST_MISS;
      end else begin
         status_in = (!match_ff && st.full) ? ST_FULL : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         total_ff <= '0;
      end else if (cmd.commit) begin
         total_ff <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
      end
   end

   assign count_ext = CX_W'(count_ff);
   assign count_sat = (count_ext > CX_W'(COUNT_SAT)) ? COUNT_SAT : count_ext[PCOUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_pair_count    <= count_sat;
         rsp_running_total <= total_ff;
         rsp_status        <= status_ff;
         rsp_final_res     <= fin_ff;
      end
   end

   assign st.scan_done  = (ptr_ff == fill_ff);
   assign st.pipe_empty = !s1_vld_ff && !s2_vld_ff && !s3_vld_ff;
   assign st.match      = match_ff;
   assign st.full       = (fill_ff == CNT_W'(CAPACITY));
   assign st.leave      = (op_ff == OP_LEAVE);
   assign st.last       = fin_ff;

endmodule

[src/bichromatic_close_pair_sweep.sv]
`timescale 1ns / 1ps
// ============================================================================
// bichromatic_close_pair_sweep
// Plane-sweep counter of close point pairs of opposite color.
// ============================================================================
// Flow: an event is taken only in idle; the block then stalls input while
//   it scans the table, updates it (a leave that removes a point also
//   moves the top entry into the hole) and loads the response, and a held
//   result holds that load. The scan reads one stored point a cycle through
//   the single read port of the point table.
// Reset (synchronous): table emptied via its fill count, total zeroed,
//   radius set to 1; no clearing sweep, first event accepted right away.
module bichromatic_close_pair_sweep
   import cbps_pkg::*;
#(
   parameter int CAPACITY  = 1024,
   parameter int COORD_MAX = 10000
)(
   input  logic                clock,
   input  logic                reset,
   // input transaction
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [COORD_W-1:0]  req_pos_x,
   input  logic [COORD_W-1:0]  req_pos_y,
   input  logic                req_color,
   input  logic                req_last,
   // result transaction
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PCOUNT_W-1:0] rsp_pair_count,
   output logic [TOTAL_W-1:0]  rsp_running_total,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_final_res,
   // radius register
   input  logic                csr_wr_en,
   input  logic [RADIUS_W-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type st;

   // Sequencer: accepts one transaction, runs the scan, then the table update
   // and the response load; the response register lets the next transaction
   // in while the previous result waits on rsp_stall.
   cbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Datapath: packed point table, four-stage scan pipeline
   // (read, difference, square, compare and count), totals.
   cbps_dp #(
      .CAPACITY  (CAPACITY),
      .COORD_MAX (COORD_MAX)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_op            (req_op),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_color         (req_color),
      .req_last          (req_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_pair_count    (rsp_pair_count),
      .rsp_running_total (rsp_running_total),
      .rsp_status        (rsp_status),
      .rsp_final_res     (rsp_final_res)
   );

endmodule

[src/cbps_chk.sv]
`timescale 1ns / 1ps
// ============================================================================
// cbps_chk
// Port-level checks of the sweep block, bound to the top level.
// ============================================================================
module cbps_chk
   import cbps_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [PCOUNT_W-1:0] rsp_pair_count,
   input logic [TOTAL_W-1:0]  rsp_running_total,
   input logic [STATUS_W-1:0] rsp_status
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_running_total) &&
                                    $stable(rsp_status) && $stable(rsp_pair_count)))
      else $error("stalled result changed");

   // one transaction at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while busy");

   // no result can appear in the cycle after an accept
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result too early");

   // a missed leave never reports pairs
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_MISS)) |-> (rsp_pair_count == '0))
      else $error("leave result with pairs");

   // reset empties the result register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bichromatic_close_pair_sweep cbps_chk u_cbps_chk (.*);
